>>> hw/rtl/rr_srdf_task_scheduler_macros.svh
// Assertion macros for the task scheduler.
// Included by the modules that carry concurrent checks.
`ifndef RR_SRDF_TASK_SCHEDULER_MACROS_SVH
`define RR_SRDF_TASK_SCHEDULER_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define RST_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Implication checked on every clock edge, reset included.
`define ALW_ASSERT(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

>>> hw/rtl/rrsdf_pkg.sv
// Package of the task scheduler: widths, codes and shared types.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
package rrsdf_pkg;
    localparam int MaxTasks = 16;
    localparam int SlotW = $clog2(MaxTasks);
    localparam int CntW = $clog2(MaxTasks + 1);
    localparam logic [9:0] DistUnknown = 10'd999;

    localparam logic [2:0] M_ADD = 3'd0;
    localparam logic [2:0] M_REMOVE = 3'd1;
    localparam logic [2:0] M_SCHED = 3'd2;
    localparam logic [2:0] M_MOVE = 3'd3;
    localparam logic [2:0] M_LOC = 3'd4;
    localparam logic [2:0] M_BLOCK = 3'd5;
    localparam logic [2:0] M_GRANT = 3'd6;
    localparam logic [2:0] M_UNDEF = 3'd7;

    localparam logic [1:0] K_TURN = 2'd0;
    localparam logic [1:0] K_ACC = 2'd1;
    localparam logic [1:0] K_NF = 2'd2;
    localparam logic [1:0] K_FULL = 2'd3;

    localparam logic CfgAlg = 1'b0;
    localparam logic CfgQuantum = 1'b1;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] task_id;
        logic [7:0] pos_x;
        logic [7:0] pos_y;
        logic [7:0] resource_id;
        logic [9:0] start_distance;
    } t_req;

    typedef struct packed {
        logic [7:0] out_task;
        logic [1:0] kind;
        logic [9:0] new_distance;
        logic last;
    } t_res;
endpackage

>>> hw/rtl/rrsdf_front.sv
// Front part: accepts requests, drops undefined modes, saturates the start
// distance and holds a two-entry queue towards the back part. Uses rrsdf_pkg.
`timescale 1ns / 1ps
`include "rr_srdf_task_scheduler_macros.svh"
module rrsdf_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  rrsdf_pkg::t_req  i_req,
    output logic             o_valid,
    input  logic             i_ready,
    output rrsdf_pkg::t_req  o_req
);
    rrsdf_pkg::t_req r_q [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    rrsdf_pkg::t_req w_in;
    logic w_push, w_pop, w_take;

    always_comb begin
        w_in = i_req;
        if (i_req.start_distance > rrsdf_pkg::DistUnknown) begin
            w_in.start_distance = rrsdf_pkg::DistUnknown;
        end
    end

    assign o_ready = (r_cnt != 2'd2);
    assign w_take = i_valid && o_ready;
    assign w_push = w_take && (i_req.mode != rrsdf_pkg::M_UNDEF);
    assign o_valid = (r_cnt != 2'd0);
    assign w_pop = o_valid && i_ready;
    assign o_req = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_in;
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    `RST_ASSERT(a_no_over, i_clk, i_rst_n, (r_cnt == 2'd2) |-> !w_push, "queue overflow")
    `RST_ASSERT(a_cnt_rng, i_clk, i_rst_n, r_cnt != 2'd3, "queue count out of range")
    `RST_ASSERT(a_no_undef, i_clk, i_rst_n, o_valid |-> (o_req.mode != rrsdf_pkg::M_UNDEF), "undefined mode queued")
endmodule

>>> hw/rtl/rrsdf_back.sv
// Back part: task table, ready queue and event sequencer with a result
// register. Searches and the insertion sort step one entry a cycle. Uses rrsdf_pkg.
`timescale 1ns / 1ps
`include "rr_srdf_task_scheduler_macros.svh"
module rrsdf_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [7:0]       i_cfg_data,
    input  logic             i_valid,
    output logic             o_ready,
    input  rrsdf_pkg::t_req  i_req,
    output logic             o_valid,
    input  logic             i_ready,
    output rrsdf_pkg::t_res  o_res
);
    localparam int SW = rrsdf_pkg::SlotW;
    localparam int CW = rrsdf_pkg::CntW;
    localparam int N = rrsdf_pkg::MaxTasks;

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_FIND = 10'b0000000010,
        S_POS  = 10'b0000000100,
        S_EXEC = 10'b0000001000,
        S_DROP = 10'b0000010000,
        S_SORT = 10'b0000100000,
        S_SHFT = 10'b0001000000,
        S_UNK  = 10'b0010000000,
        S_HEAD = 10'b0100000000,
        S_OUT  = 10'b1000000000
    } t_state;

    t_state r_st;
    rrsdf_pkg::t_req r_req;
    logic [7:0] r_ident [N];
    logic [7:0] r_wx [N];
    logic [7:0] r_wy [N];
    logic [9:0] r_dist [N];
    logic [7:0] r_ql [N];
    logic [N-1:0] r_vld, r_blk, r_sch, r_end;
    logic [SW-1:0] r_ord [N];
    logic [CW-1:0] r_rc;
    logic r_alg;
    logic [7:0] r_quant;
    logic [CW-1:0] r_i, r_j;
    logic [SW-1:0] r_slot, r_key;
    logic r_found, r_pfound;
    logic [CW-1:0] r_p;
    logic r_after;
    rrsdf_pkg::t_res r_out;
    logic r_ov;
    logic [SW-1:0] w_i, w_j, w_jm;

    assign w_i = r_i[SW-1:0];
    assign w_j = r_j[SW-1:0];
    assign w_jm = w_j - 1'b1;
    assign o_ready = (r_st == S_IDLE) && !r_ov;
    assign o_valid = r_ov;
    assign o_res = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_vld <= '0;
            r_blk <= '0;
            r_sch <= '0;
            r_end <= '0;
            r_rc <= '0;
            r_alg <= 1'b0;
            r_quant <= 8'd3;
            r_ov <= 1'b0;
            for (int k = 0; k < N; k++) begin
                r_wx[k] <= '0;
                r_wy[k] <= '0;
                r_ql[k] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == rrsdf_pkg::CfgAlg) begin
                    r_alg <= i_cfg_data[0];
                end else begin
                    r_quant <= i_cfg_data;
                end
            end
            if (r_ov && i_ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_st)
                S_IDLE: begin
                    if (i_valid && !r_ov) begin
                        r_req <= i_req;
                        r_i <= '0;
                        r_found <= 1'b0;
                        r_pfound <= 1'b0;
                        r_slot <= '0;
                        if (i_req.mode == rrsdf_pkg::M_SCHED) begin
                            r_st <= S_HEAD;
                        end else begin
                            r_st <= S_FIND;
                        end
                    end
                end
                S_FIND: begin
                    if (!r_found && r_vld[w_i] && r_ident[w_i] == r_req.task_id) begin
                        r_found <= 1'b1;
                        r_slot <= w_i;
                    end
                    if (r_i == CW'(N - 1)) begin
                        r_i <= '0;
                        r_st <= S_POS;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                S_POS: begin
                    if (r_i < r_rc && !r_pfound && r_ord[w_i] == r_slot) begin
                        r_pfound <= 1'b1;
                        r_p <= r_i;
                    end
                    if (r_i >= r_rc) begin
                        r_st <= S_EXEC;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                S_EXEC: begin
                    r_out.out_task <= r_req.task_id;
                    r_out.kind <= rrsdf_pkg::K_ACC;
                    r_out.new_distance <= '0;
                    r_out.last <= 1'b1;
                    r_st <= S_OUT;
                    if (r_req.mode == rrsdf_pkg::M_ADD) begin
                        if (!r_found) begin
                            if (&r_vld) begin
                                r_out.kind <= rrsdf_pkg::K_FULL;
                            end else begin
                                for (int k = N - 1; k >= 0; k--) begin
                                    if (!r_vld[k]) begin
                                        r_slot <= SW'(k);
                                    end
                                end
                                r_st <= S_DROP;
                                r_after <= 1'b1;
                            end
                        end
                    end else if (!r_found) begin
                        r_out.kind <= rrsdf_pkg::K_NF;
                    end else begin
                        case (r_req.mode)
                            rrsdf_pkg::M_REMOVE: begin
                                r_vld[r_slot] <= 1'b0;
                                r_blk[r_slot] <= 1'b0;
                                r_sch[r_slot] <= 1'b0;
                                r_end[r_slot] <= 1'b0;
                                r_ql[r_slot] <= '0;
                                if (r_pfound) begin
                                    r_i <= r_p;
                                    r_after <= 1'b0;
                                    r_st <= S_DROP;
                                end
                            end
                            rrsdf_pkg::M_MOVE: begin
                                if (!r_pfound) begin
                                    r_out.kind <= rrsdf_pkg::K_NF;
                                end else begin
                                    r_wx[r_slot] <= r_req.pos_x;
                                    r_wy[r_slot] <= r_req.pos_y;
                                    if (!r_alg && r_ql[r_slot] > 8'd1) begin
                                        r_ql[r_slot] <= r_ql[r_slot] - 8'd1;
                                    end else if (!r_alg || r_ql[r_slot] == 8'd0) begin
                                        r_ql[r_slot] <= '0;
                                        r_end[r_slot] <= 1'b1;
                                    end
                                    r_sch[r_slot] <= 1'b0;
                                end
                            end
                            rrsdf_pkg::M_LOC: begin
                                if (!r_pfound) begin
                                    r_out.kind <= rrsdf_pkg::K_NF;
                                end else begin
                                    r_out.new_distance <= 10'(
                                        ((r_req.pos_x > r_wx[r_slot]) ? r_req.pos_x - r_wx[r_slot]
                                            : r_wx[r_slot] - r_req.pos_x) +
                                        {1'b0, ((r_req.pos_y > r_wy[r_slot])
                                            ? r_req.pos_y - r_wy[r_slot]
                                            : r_wy[r_slot] - r_req.pos_y)});
                                    r_dist[r_slot] <= 10'(
                                        ((r_req.pos_x > r_wx[r_slot]) ? r_req.pos_x - r_wx[r_slot]
                                            : r_wx[r_slot] - r_req.pos_x) +
                                        {1'b0, ((r_req.pos_y > r_wy[r_slot])
                                            ? r_req.pos_y - r_wy[r_slot]
                                            : r_wy[r_slot] - r_req.pos_y)});
                                    r_sch[r_slot] <= 1'b0;
                                end
                            end
                            rrsdf_pkg::M_BLOCK: begin
                                if (!r_pfound) begin
                                    r_out.kind <= rrsdf_pkg::K_NF;
                                end else begin
                                    r_blk[r_slot] <= 1'b1;
                                    r_sch[r_slot] <= 1'b0;
                                    r_end[r_slot] <= 1'b0;
                                    r_ql[r_slot] <= '0;
                                    r_dist[r_slot] <= rrsdf_pkg::DistUnknown;
                                    r_i <= r_p;
                                    r_after <= 1'b0;
                                    r_st <= S_DROP;
                                end
                            end
                            default: begin
                                if (!r_blk[r_slot] || r_pfound) begin
                                    r_out.kind <= rrsdf_pkg::K_NF;
                                end else begin
                                    r_blk[r_slot] <= 1'b0;
                                    if (r_rc < CW'(N)) begin
                                        r_ord[r_rc[SW-1:0]] <= r_slot;
                                        r_rc <= r_rc + 1'b1;
                                    end
                                end
                            end
                        endcase
                    end
                end
                S_DROP: begin
                    if (r_after) begin
                        r_ident[r_slot] <= r_req.task_id;
                        r_wx[r_slot] <= '0;
                        r_wy[r_slot] <= '0;
                        r_dist[r_slot] <= r_req.start_distance;
                        r_ql[r_slot] <= '0;
                        r_vld[r_slot] <= 1'b1;
                        r_blk[r_slot] <= 1'b0;
                        r_sch[r_slot] <= 1'b0;
                        r_end[r_slot] <= 1'b0;
                        if (r_rc < CW'(N)) begin
                            r_ord[r_rc[SW-1:0]] <= r_slot;
                            r_rc <= r_rc + 1'b1;
                        end
                        r_st <= S_OUT;
                    end else if (r_i + 1'b1 < r_rc) begin
                        r_ord[w_i] <= r_ord[SW'(r_i + 1'b1)];
                        r_i <= r_i + 1'b1;
                    end else begin
                        if (r_rc != '0) begin
                            r_rc <= r_rc - 1'b1;
                        end
                        r_st <= S_OUT;
                    end
                end
                S_HEAD: begin
                    if (!r_pfound) begin
                        r_out.new_distance <= '0;
                        r_out.last <= 1'b1;
                        r_out.kind <= rrsdf_pkg::K_TURN;
                        if (r_rc == '0) begin
                            r_out.out_task <= '0;
                            r_out.kind <= rrsdf_pkg::K_NF;
                            r_st <= S_OUT;
                        end else if (r_sch[r_ord[0]]) begin
                            r_st <= S_IDLE;
                        end else if (!r_alg) begin
                            if (r_ql[r_ord[0]] != 8'd0) begin
                                r_sch[r_ord[0]] <= 1'b1;
                                r_out.out_task <= r_ident[r_ord[0]];
                                r_st <= S_OUT;
                            end else if (!r_end[r_ord[0]]) begin
                                r_ql[r_ord[0]] <= r_quant;
                                r_sch[r_ord[0]] <= 1'b1;
                                r_out.out_task <= r_ident[r_ord[0]];
                                r_st <= S_OUT;
                            end else begin
                                r_sch[r_ord[0]] <= 1'b0;
                                r_key <= r_ord[0];
                                r_i <= '0;
                                r_st <= S_SHFT;
                            end
                        end else if (r_ql[r_ord[0]] == 8'd0) begin
                            r_i <= CW'(1);
                            r_j <= CW'(1);
                            r_key <= r_ord[1];
                            r_st <= S_SORT;
                        end else begin
                            r_i <= '0;
                            r_st <= S_UNK;
                        end
                    end
                end
                S_SHFT: begin
                    if (r_i + 1'b1 < r_rc) begin
                        r_ord[w_i] <= r_ord[SW'(r_i + 1'b1)];
                        r_i <= r_i + 1'b1;
                    end else begin
                        r_ord[w_i] <= r_key;
                        r_end[r_ord[0]] <= 1'b0;
                        r_i <= '0;
                        r_found <= 1'b1;
                        r_st <= S_UNK;
                    end
                end
                S_SORT: begin
                    if (r_i >= r_rc || r_i == CW'(N)) begin
                        r_ql[r_ord[0]] <= 8'd1;
                        r_sch[r_ord[0]] <= 1'b1;
                        r_out.out_task <= r_ident[r_ord[0]];
                        r_st <= S_OUT;
                    end else if (r_j != '0 && r_dist[r_key] < r_dist[r_ord[w_jm]]) begin
                        r_ord[w_j] <= r_ord[w_jm];
                        r_j <= r_j - 1'b1;
                    end else begin
                        r_ord[w_j] <= r_key;
                        r_i <= r_i + 1'b1;
                        r_j <= r_i + 1'b1;
                        r_key <= r_ord[SW'(r_i + 1'b1)];
                    end
                end
                S_UNK: begin
                    if (r_found) begin
                        r_ql[r_ord[0]] <= r_quant;
                        r_sch[r_ord[0]] <= 1'b1;
                        r_out.out_task <= r_ident[r_ord[0]];
                        r_st <= S_OUT;
                    end else if (r_i >= r_rc) begin
                        r_sch[r_ord[0]] <= 1'b1;
                        r_out.out_task <= r_ident[r_ord[0]];
                        r_st <= S_OUT;
                    end else if (r_dist[r_ord[w_i]] == rrsdf_pkg::DistUnknown) begin
                        r_out.out_task <= r_ident[r_ord[w_i]];
                        r_out.last <= 1'b0;
                        r_sch[r_ord[0]] <= 1'b1;
                        r_ov <= 1'b1;
                        r_i <= CW'(N);
                        r_st <= S_HEAD;
                        r_slot <= r_ord[0];
                        r_pfound <= 1'b1;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                S_OUT: begin
                    if (!r_ov) begin
                        r_ov <= 1'b1;
                        r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
            if (r_st == S_HEAD && r_pfound && r_req.mode == rrsdf_pkg::M_SCHED) begin
                if (!r_ov || i_ready) begin
                    r_out.out_task <= r_ident[r_slot];
                    r_out.kind <= rrsdf_pkg::K_TURN;
                    r_out.new_distance <= '0;
                    r_out.last <= 1'b1;
                    r_ov <= 1'b1;
                    r_st <= S_IDLE;
                end else begin
                    r_st <= S_HEAD;
                end
            end
        end
    end

    `RST_ASSERT(a_rc_rng, i_clk, i_rst_n, r_rc <= CW'(N), "ready count above table size")
    `RST_ASSERT(a_idle_out, i_clk, i_rst_n, (r_st == S_OUT && !r_ov) |=> r_ov, "result lost")
    `RST_ASSERT(a_hold, i_clk, i_rst_n, (r_ov && !i_ready) |=> $stable(r_out), "result changed while held")
endmodule

>>> hw/rtl/rr_srdf_task_scheduler.sv
// Top level of the task scheduler: front queue and back sequencer.
// Depends on rrsdf_pkg, rrsdf_front and rrsdf_back.
// Throughput: one request at a time in the back part, taken only once the previous
// result has been accepted; two requests queue ahead. Reset is synchronous and
// active low; it empties the queues, clears the task flags, positions and quanta, and resets configuration and state.
`timescale 1ns / 1ps
module rr_srdf_task_scheduler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_mode,
    input  logic [7:0]  i_task_id,
    input  logic [7:0]  i_pos_x,
    input  logic [7:0]  i_pos_y,
    input  logic [7:0]  i_resource_id,
    input  logic [9:0]  i_start_distance,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_out_task,
    output logic [1:0]  o_kind,
    output logic [9:0]  o_new_distance,
    output logic        o_last
);
    rrsdf_pkg::t_req w_req, w_qreq;
    rrsdf_pkg::t_res w_res;
    logic w_qv, w_qr;

    assign w_req = '{mode: i_mode, task_id: i_task_id, pos_x: i_pos_x, pos_y: i_pos_y,
                     resource_id: i_resource_id, start_distance: i_start_distance};

    rrsdf_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_req(w_req), .o_valid(w_qv), .i_ready(w_qr), .o_req(w_qreq)
    );

    rrsdf_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_valid(w_qv), .o_ready(w_qr), .i_req(w_qreq),
        .o_valid(o_valid), .i_ready(i_ready), .o_res(w_res)
    );

    assign o_out_task = w_res.out_task;
    assign o_kind = w_res.kind;
    assign o_new_distance = w_res.new_distance;
    assign o_last = w_res.last;
endmodule
